@@ hdl/periodic_deadline_scheduler_top_defines.svh @@
// Assertion macros used by the scheduler engine.
`ifndef PERIODIC_DEADLINE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_DEADLINE_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PDS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PDS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/pds_pkg.sv @@
// Shared types and constants of the periodic deadline scheduler.
package pds_pkg;
    localparam int unsigned SLOTS_DEF = 16;
    localparam int unsigned MAX_FIRES = 16;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CMPL  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FIRED   = 3'd1;
    localparam logic [2:0] ST_ACK     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_TICKEND = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;
    localparam logic [2:0] ST_REFUSED = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] interval;
        logic [15:0] task_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_id;
        logic        hit;
        logic        last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_END
    } t_state;
endpackage

@@ hdl/pds_fifo.sv @@
// Small register queue between the scheduler stages.
module pds_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (w_do_push) begin
            n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (w_do_pop) begin
            n_rp = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

@@ hdl/pds_engine.sv @@
// Back part: keeps the slot table and carries out one request at a time.
module pds_engine #(
    parameter int unsigned SLOTS = pds_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enable,
    input  logic          i_req_valid,
    input  pds_pkg::t_req i_req,
    output logic          o_req_pop,
    output logic          o_res_push,
    output pds_pkg::t_res o_res,
    input  logic          i_res_full
);
    import pds_pkg::*;
    `include "periodic_deadline_scheduler_top_defines.svh"

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned FW = $clog2(MAX_FIRES + 1);

    logic [SLOTS-1:0] r_valid, r_active, r_done;
    logic [15:0]      r_ident [SLOTS];
    logic [15:0]      r_period [SLOTS];
    logic [31:0]      r_dl [SLOTS];
    logic [31:0]      r_time;
    logic [15:0]      r_idc;
    t_state           r_state, n_state;
    logic [SW:0]      r_idx;
    logic             r_bvalid;
    logic [SW-1:0]    r_best;
    logic [31:0]      r_bage;
    logic [15:0]      r_bid;
    logic [FW-1:0]    r_nfire;

    // Combinational helpers.
    logic [SW-1:0]    w_cur;
    logic [31:0]      w_age;
    logic             w_cand, w_better;
    logic             w_has_free;
    logic [SW-1:0]    w_free;
    logic [SLOTS-1:0] w_match;
    logic             w_imm;
    t_res             w_imm_res;
    logic [15:0]      w_ivl;

    assign w_cur = r_idx[SW-1:0];
    assign w_age = r_time - r_dl[w_cur];
    assign w_cand = r_valid[w_cur] && !r_done[w_cur] && !w_age[31];
    assign w_better = !r_bvalid || (w_age > r_bage)
        || (w_age == r_bage && r_ident[w_cur] < r_bid);
    assign w_ivl = (i_req.interval == '0) ? 16'd1 : i_req.interval;

    always_comb begin
        w_has_free = 1'b0;
        w_free = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                w_has_free = 1'b1;
                w_free = SW'(s);
            end
        end
        for (int s = 0; s < SLOTS; s++) begin
            w_match[s] = r_valid[s] && (r_ident[s] == i_req.task_id);
        end
    end

    // Requests other than a tick are carried out directly in the idle state, once the result queue has room.
    assign w_imm = (r_state == S_IDLE) && i_req_valid && (i_req.req_type != REQ_TICK);

    always_comb begin
        w_imm_res = '0;
        w_imm_res.last = 1'b1;
        case (i_req.req_type)
            REQ_ADD: begin
                if (w_has_free) begin
                    w_imm_res.status = ST_ADDED;
                    w_imm_res.result_id = r_idc + 16'd1;
                end else begin
                    w_imm_res.status = ST_FULL;
                end
            end
            REQ_CMPL: begin
                w_imm_res.status = ST_ACK;
                w_imm_res.result_id = i_req.task_id;
                w_imm_res.hit = |w_match;
            end
            REQ_CLEAR: begin
                w_imm_res.status = i_enable ? ST_REFUSED : ST_CLEARED;
            end
            default: begin
                w_imm_res.status = ST_TICKEND;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_req.req_type == REQ_TICK) begin
                    n_state = i_enable ? S_SCAN : S_END;
                end
            end
            S_SCAN: begin
                if (r_idx == (SW+1)'(SLOTS - 1)) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (!r_bvalid) begin
                    n_state = S_END;
                end else if (r_active[r_best]) begin
                    if (r_nfire == FW'(MAX_FIRES)) begin
                        n_state = S_END;
                    end else if (!i_res_full) begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_END: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_pop = 1'b0;
        o_res_push = 1'b0;
        o_res = '0;
        case (r_state)
            S_IDLE: begin
                if (w_imm && !i_res_full) begin
                    o_req_pop = 1'b1;
                    o_res_push = 1'b1;
                    o_res = w_imm_res;
                end
            end
            S_ACT: begin
                if (r_bvalid && r_active[r_best] && r_nfire != FW'(MAX_FIRES)) begin
                    o_res_push = !i_res_full;
                    o_res.status = ST_FIRED;
                    o_res.result_id = r_bid;
                end
            end
            S_END: begin
                o_res_push = !i_res_full;
                o_req_pop = !i_res_full;
                o_res.status = ST_TICKEND;
                o_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_active <= '0;
            r_done   <= '0;
            r_time   <= '0;
            r_idc    <= '0;
            r_idx    <= '0;
            r_bvalid <= 1'b0;
            r_nfire  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_bvalid <= 1'b0;
                    r_done   <= '0;
                    r_nfire  <= '0;
                    if (i_req_valid && i_req.req_type == REQ_TICK) begin
                        r_time <= r_time + 32'd1;
                    end
                    if (w_imm && !i_res_full) begin
                        case (i_req.req_type)
                            REQ_ADD: begin
                                if (w_has_free) begin
                                    r_idc <= r_idc + 16'd1;
                                    r_valid[w_free]  <= 1'b1;
                                    r_active[w_free] <= 1'b1;
                                end
                            end
                            REQ_CMPL: r_active <= r_active & ~w_match;
                            REQ_CLEAR: begin
                                if (!i_enable) begin
                                    r_valid  <= '0;
                                    r_active <= '0;
                                    r_idc    <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_cand && w_better) begin
                        r_bvalid <= 1'b1;
                        r_best   <= w_cur;
                        r_bage   <= w_age;
                        r_bid    <= r_ident[w_cur];
                    end
                end
                S_ACT: begin
                    r_idx    <= '0;
                    r_bvalid <= 1'b0;
                    if (r_bvalid && !r_active[r_best]) begin
                        r_valid[r_best] <= 1'b0;
                    end else if (r_bvalid && r_nfire != FW'(MAX_FIRES) && !i_res_full) begin
                        r_done[r_best] <= 1'b1;
                        r_nfire <= r_nfire + 1'b1;
                    end else begin
                        r_bvalid <= r_bvalid;
                    end
                end
                default: ;
            endcase
        end
    end

    // Slot payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_imm && !i_res_full && i_req.req_type == REQ_ADD && w_has_free) begin
            r_ident[w_free]  <= r_idc + 16'd1;
            r_period[w_free] <= w_ivl;
            r_dl[w_free]     <= r_time + {16'd0, w_ivl};
        end
        if (r_state == S_ACT && r_bvalid && r_active[r_best]
                && r_nfire != FW'(MAX_FIRES) && !i_res_full) begin
            r_dl[r_best] <= r_time + {16'd0, r_period[r_best]};
        end
    end

    `PDS_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_res_push, !i_res_full, "push into full queue")
    `PDS_ASSERT_IMP(a_pop_last, i_clk, i_rst_n, o_req_pop, o_res_push && o_res.last, "request retired without last result")
    `PDS_ASSERT_IMP(a_fire_cap, i_clk, i_rst_n, r_state != S_IDLE, r_nfire <= FW'(MAX_FIRES), "fire count above cap")
    `PDS_ASSERT_NXT(a_tick_time, i_clk, i_rst_n, r_state == S_IDLE && i_req_valid && i_req.req_type == REQ_TICK, r_time == $past(r_time) + 32'd1, "time did not advance")
endmodule

@@ hdl/periodic_deadline_scheduler_top.sv @@
// Top level of the periodic deadline scheduler.
//  channel  | handshake              | payload
//  request  | push / full            | i_req_type, i_interval, i_task_id
//  result   | empty / pop            | o_status, o_result_id, o_hit, o_last
//  config   | i_enable_we            | i_enable_data
// Add, complete and clear are carried out by the engine directly from idle. A
// tick starts, runs a deadline scan over all slots for each entry that it
// fires or retires plus one final scan while enabled, and then gives its end
// result; while disabled it goes straight to its end result. Reset is synchronous
// and leaves the table empty. Requests wait in a two-entry queue; results in a
// four-entry queue, whose fill stalls the engine.
module periodic_deadline_scheduler_top #(
    parameter int unsigned SLOTS = pds_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_interval,
    input  logic [15:0] i_task_id,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_result_id,
    output logic        o_hit,
    output logic        o_last,
    input  logic        i_enable_we,
    input  logic        i_enable_data
);
    import pds_pkg::*;

    logic r_enable;
    t_req w_in_req, w_q_req;
    t_res w_res_in, w_res_out;
    logic w_q_empty, w_q_pop, w_res_push, w_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_enable_we) begin
            r_enable <= i_enable_data;
        end
    end

    assign w_in_req = '{req_type: i_req_type, interval: i_interval, task_id: i_task_id};

    pds_fifo #(.WIDTH($bits(t_req)), .DEPTH(2)) u_req_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(w_in_req), .o_full(full),
        .i_pop(w_q_pop), .o_data(w_q_req), .o_empty(w_q_empty)
    );

    pds_engine #(.SLOTS(SLOTS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_enable(r_enable),
        .i_req_valid(!w_q_empty), .i_req(w_q_req), .o_req_pop(w_q_pop),
        .o_res_push(w_res_push), .o_res(w_res_in), .i_res_full(w_res_full)
    );

    pds_fifo #(.WIDTH($bits(t_res)), .DEPTH(4)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_res_push), .i_data(w_res_in), .o_full(w_res_full),
        .i_pop(pop), .o_data(w_res_out), .o_empty(empty)
    );

    assign o_status    = w_res_out.status;
    assign o_result_id = w_res_out.result_id;
    assign o_hit       = w_res_out.hit;
    assign o_last      = w_res_out.last;
endmodule
